[rtl/core/rgr_pkg.sv]
// ----------------------------------------------------------------------------
// Range gamma remap package
// Shared constants, register indexes, the sideband type that travels along
// the pipeline, and elaboration-time helpers for the exp2 root table.
// ----------------------------------------------------------------------------
package rgr_pkg;

    // Fraction bits of the log2 domain and of the gamma register.
    localparam int LOGF       = 30;
    localparam int GAMMA_FRAC = 16;
    localparam logic [23:0] GAMMA_FLOOR = 24'd7;

    // Widths of the exponent and integer power carried in the sideband.
    localparam int EXPW = 6;
    localparam int IPW  = 16;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_CONST_MODE  = 3'd0;
    localparam logic [2:0] REG_CONST_VALUE = 3'd1;
    localparam logic [2:0] REG_INPUT_MIN   = 3'd2;
    localparam logic [2:0] REG_INPUT_MAX   = 3'd3;
    localparam logic [2:0] REG_OUTPUT_MIN  = 3'd4;
    localparam logic [2:0] REG_OUTPUT_MAX  = 3'd5;
    localparam logic [2:0] REG_GAMMA       = 3'd6;
    localparam logic [2:0] REG_MAP_FLAGS   = 3'd7;

    // Per-sample control that rides along with the datapath.
    typedef struct packed {
        logic                   neg;   // result takes a negative sign
        logic                   zero;  // power base is zero
        logic                   sat;   // some step saturated
        logic [EXPW-1:0]        expo;  // leading-one position of the base
        logic signed [IPW-1:0]  ip;    // integer part of the power exponent
    } t_side;

    // Floored integer square root, evaluated at elaboration only.
    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = x;
        res = '0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (b > v) begin
                b = b >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 64'd0) begin
                if (v >= res + b) begin
                    v   = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
        end
        return res;
    endfunction

    // Q2.30 value of 2^(2^-k), built by repeated floored square roots.
    function automatic logic [31:0] exp2_root(input int k);
        logic [63:0] c;
        c = 64'd2 << LOGF;
        for (int j = 1; j <= LOGF; j++) begin
            if (j <= k) begin
                c = isqrt64(c << LOGF);
            end
        end
        return c[31:0];
    endfunction

endpackage

[rtl/core/rgr_div_cell.sv]
// ----------------------------------------------------------------------------
// Divider cell
// One restoring-division step: shifts in one dividend bit, subtracts the
// divisor when it fits and shifts the quotient bit into the word.
// ----------------------------------------------------------------------------
module rgr_div_cell #(
    parameter int QW = 49
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic [31:0]     i_width,
    input  logic            i_valid,
    input  logic [31:0]     i_rem,
    input  logic [QW-1:0]   i_dq,
    input  rgr_pkg::t_side  i_side,
    output logic            o_valid,
    output logic [31:0]     o_rem,
    output logic [QW-1:0]   o_dq,
    output rgr_pkg::t_side  o_side
);
    import rgr_pkg::*;

    logic [32:0] n_trial;
    logic [32:0] n_diff;
    logic        n_fits;

    // Trial subtract of the divisor from the shifted remainder.
    always_comb begin
        n_trial = {i_rem, i_dq[QW-1]};
        n_diff  = n_trial - {1'b0, i_width};
        n_fits  = (n_trial >= {1'b0, i_width});
    end

    logic            r_valid;
    logic [31:0]     r_rem;
    logic [QW-1:0]   r_dq;
    t_side           r_side;

    // Valid bit of the cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Remainder and quotient word.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_fits ? n_diff[31:0] : n_trial[31:0];
            r_dq   <= {i_dq[QW-2:0], n_fits};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_dq    = r_dq;
    assign o_side  = r_side;

endmodule

[rtl/core/rgr_log_cell.sv]
// ----------------------------------------------------------------------------
// Log2 cell
// Squares the normalized mantissa once and yields one fraction bit of the
// base-2 logarithm.
// ----------------------------------------------------------------------------
module rgr_log_cell #(
    parameter int BIT = 29
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [30:0]     i_m,
    input  logic [29:0]     i_f,
    input  rgr_pkg::t_side  i_side,
    output logic            o_valid,
    output logic [30:0]     o_m,
    output logic [29:0]     o_f,
    output rgr_pkg::t_side  o_side
);
    import rgr_pkg::*;

    logic [61:0] n_sq;
    logic [31:0] n_hi;

    // Truncating square in Q1.30; a carry into bit 31 means the bit is one.
    always_comb begin
        n_sq = i_m * i_m;
        n_hi = n_sq[61:30];
    end

    logic         r_valid;
    logic [30:0]  r_m;
    logic [29:0]  r_f;
    t_side        r_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Renormalize and record the fraction bit.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m    <= n_hi[31] ? n_hi[31:1] : n_hi[30:0];
            r_f    <= i_f | (30'(n_hi[31]) << BIT);
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_m     = r_m;
    assign o_f     = r_f;
    assign o_side  = r_side;

endmodule

[rtl/core/rgr_exp_cell.sv]
// ----------------------------------------------------------------------------
// Exp2 cell
// Multiplies the mantissa by the root constant 2^(2^-K) when fraction bit
// LOGF-K of the exponent is set, rounding half up.
// ----------------------------------------------------------------------------
module rgr_exp_cell #(
    parameter int K = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [31:0]     i_m,
    input  logic [29:0]     i_fp,
    input  rgr_pkg::t_side  i_side,
    output logic            o_valid,
    output logic [31:0]     o_m,
    output logic [29:0]     o_fp,
    output rgr_pkg::t_side  o_side
);
    import rgr_pkg::*;

    localparam logic [31:0] ROOT = exp2_root(K);

    logic [63:0] n_prod;

    // Rounded Q2.30 product.
    always_comb begin
        n_prod = i_m * ROOT + (64'd1 << (LOGF - 1));
    end

    logic         r_valid;
    logic [31:0]  r_m;
    logic [29:0]  r_fp;
    t_side        r_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m    <= i_fp[LOGF-K] ? n_prod[61:30] : i_m;
            r_fp   <= i_fp;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_m     = r_m;
    assign o_fp    = r_fp;
    assign o_side  = r_side;

endmodule

[rtl/core/range_gamma_remap_core.sv]
// ----------------------------------------------------------------------------
// Range gamma remap core
// Maps each Q16.16 sample through a linear range remap with an optional
// invert, clamp and gamma power, saturating the result.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_axis stream (tdata = field_value). Results leave on
//   the m_axis stream (tdata = mapped_value, tuser = saturated flag).
//   The APB port holds eight registers at byte addresses 0x00 to 0x1C; write
//   them only while no beat is in flight.
//   Throughput is one beat per cycle while the receiver keeps up. The
//   pipeline holds one cell per quotient bit in the divider row
//   (33 + FRAC_BITS cells), one per log2 fraction bit (30 squaring cells), one
//   per exp2 fraction bit (30 multiply cells), plus eleven single stages for
//   the input offset, quotient saturate, invert, clamp, leading-one search,
//   normalize, gamma scale, exponent split, final shift, span product and
//   output register.
//   When the receiver stalls, the output register holds its beat; the row of
//   cells keeps moving as long as the span product stage is empty, so input
//   beats are still taken until the pipeline backs up.
//   Synchronous reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module range_gamma_remap_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] field_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] mapped_value
    output logic [0:0]  m_axis_tuser,   // [0] saturated
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rgr_pkg::*;

    localparam int QW = 33 + FRAC_BITS;
    localparam logic [QW-1:0] QPOS_MAX = QW'(32'h7FFF_FFFF);
    localparam logic [QW-1:0] QNEG_MAX = QW'(32'h8000_0000);
    localparam logic signed [33:0] ONE34  = 34'sd1 <<< FRAC_BITS;
    localparam logic signed [33:0] SMAX34 = 34'sd2147483647;
    localparam logic signed [33:0] SMIN34 = -34'sd2147483648;
    localparam logic signed [62:0] FOFS   = 63'(FRAC_BITS) <<< LOGF;
    localparam logic signed [64:0] RND65  = 65'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [65:0] SMAX66 = 66'sd2147483647;
    localparam logic signed [65:0] SMIN66 = -66'sd2147483648;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic               r_const_mode;
    logic signed [31:0] r_const_value;
    logic signed [31:0] r_input_min;
    logic signed [31:0] r_input_max;
    logic signed [31:0] r_output_min;
    logic signed [31:0] r_output_max;
    logic [23:0]        r_gamma;
    logic [1:0]         r_map_flags;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_const_mode  <= 1'b0;
            r_const_value <= 32'sd0;
            r_input_min   <= 32'sd0;
            r_input_max   <= 32'sd65536;
            r_output_min  <= 32'sd0;
            r_output_max  <= 32'sd65536;
            r_gamma       <= 24'd65536;
            r_map_flags   <= 2'd1;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                REG_CONST_MODE:  r_const_mode  <= pwdata[0];
                REG_CONST_VALUE: r_const_value <= pwdata;
                REG_INPUT_MIN:   r_input_min   <= pwdata;
                REG_INPUT_MAX:   r_input_max   <= pwdata;
                REG_OUTPUT_MIN:  r_output_min  <= pwdata;
                REG_OUTPUT_MAX:  r_output_max  <= pwdata;
                REG_GAMMA:       r_gamma       <= pwdata[23:0];
                REG_MAP_FLAGS:   r_map_flags   <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[4:2])
            REG_CONST_MODE:  prdata = {31'd0, r_const_mode};
            REG_CONST_VALUE: prdata = r_const_value;
            REG_INPUT_MIN:   prdata = r_input_min;
            REG_INPUT_MAX:   prdata = r_input_max;
            REG_OUTPUT_MIN:  prdata = r_output_min;
            REG_OUTPUT_MAX:  prdata = r_output_max;
            REG_GAMMA:       prdata = {8'd0, r_gamma};
            REG_MAP_FLAGS:   prdata = {30'd0, r_map_flags};
            default:         prdata = 32'd0;
        endcase
    end

    // Derived from registers; the user holds them stable in flight, unchecked.
    logic signed [32:0] n_width33;
    logic [31:0]        n_width;
    logic [23:0]        n_gamma;
    logic signed [32:0] n_span;

    always_comb begin
        n_width33 = $signed({r_input_max[31], r_input_max})
                  - $signed({r_input_min[31], r_input_min});
        n_width   = (n_width33 < 33'sd1) ? 32'd1 : n_width33[31:0];
        n_gamma   = (r_gamma < GAMMA_FLOOR) ? GAMMA_FLOOR : r_gamma;
        n_span    = $signed({r_output_max[31], r_output_max})
                  - $signed({r_output_min[31], r_output_min});
    end

    // ------------------------------------------------------------------
    // Flow control: the row halts when a blocked beat has a full stage behind.
    // ------------------------------------------------------------------
    logic en;
    logic r_out_valid;
    logic r_m_valid;
    logic n_out_load;

    assign en            = !r_out_valid || m_axis_tready || !r_m_valid;
    assign n_out_load    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    // ------------------------------------------------------------------
    // Input stage: offset and sign-magnitude dividend.
    // ------------------------------------------------------------------
    logic signed [32:0] n_diff;
    logic [32:0]        n_mag;
    logic               r_s0_valid;
    logic [QW-1:0]      r_s0_dq;
    t_side              r_s0_side;

    always_comb begin
        n_diff = $signed({s_axis_tdata[31], s_axis_tdata})
               - $signed({r_input_min[31], r_input_min});
        n_mag  = n_diff[32] ? 33'(-n_diff) : 33'(n_diff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_dq   <= {n_mag, {FRAC_BITS{1'b0}}};
            r_s0_side <= '{neg: n_diff[32], zero: 1'b0, sat: 1'b0,
                           expo: '0, ip: '0};
        end
    end

    // ------------------------------------------------------------------
    // Divider row: one quotient bit per cell.
    // ------------------------------------------------------------------
    logic          w_dval  [0:QW];
    logic [31:0]   w_drem  [0:QW];
    logic [QW-1:0] w_ddq   [0:QW];
    t_side         w_dside [0:QW];

    assign w_dval[0]  = r_s0_valid;
    assign w_drem[0]  = 32'd0;
    assign w_ddq[0]   = r_s0_dq;
    assign w_dside[0] = r_s0_side;

    for (genvar gi = 0; gi < QW; gi++) begin : g_div
        rgr_div_cell #(.QW(QW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_width (n_width),
            .i_valid (w_dval[gi]),
            .i_rem   (w_drem[gi]),
            .i_dq    (w_ddq[gi]),
            .i_side  (w_dside[gi]),
            .o_valid (w_dval[gi+1]),
            .o_rem   (w_drem[gi+1]),
            .o_dq    (w_ddq[gi+1]),
            .o_side  (w_dside[gi+1])
        );
    end

    // ------------------------------------------------------------------
    // Saturate the signed quotient to 32 bits.
    // ------------------------------------------------------------------
    logic [QW-1:0]      n_q;
    logic signed [31:0] n_n1;
    logic               n_n1_sat;
    t_side              n_n1_side;
    logic               r_n1_valid;
    logic signed [31:0] r_n1;
    t_side              r_n1_side;

    always_comb begin
        n_q      = w_ddq[QW];
        n_n1_sat = 1'b0;
        if (!w_dside[QW].neg) begin
            if (n_q > QPOS_MAX) begin
                n_n1     = 32'sh7FFF_FFFF;
                n_n1_sat = 1'b1;
            end else begin
                n_n1 = n_q[31:0];
            end
        end else begin
            if (n_q > QNEG_MAX) begin
                n_n1     = 32'sh8000_0000;
                n_n1_sat = 1'b1;
            end else begin
                n_n1 = -$signed(n_q[31:0]);
            end
        end
        n_n1_side     = w_dside[QW];
        n_n1_side.sat = n_n1_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n1_valid <= 1'b0;
        end else if (en) begin
            r_n1_valid <= w_dval[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n1      <= n_n1;
            r_n1_side <= n_n1_side;
        end
    end

    // ------------------------------------------------------------------
    // Optional invert, saturated.
    // ------------------------------------------------------------------
    logic signed [33:0] n_inv;
    logic signed [31:0] n_n2;
    logic               n_n2_sat;
    t_side              n_n2_side;
    logic               r_n2_valid;
    logic signed [31:0] r_n2;
    t_side              r_n2_side;

    always_comb begin
        n_inv    = ONE34 - $signed({{2{r_n1[31]}}, r_n1});
        n_n2     = r_n1;
        n_n2_sat = 1'b0;
        if (r_map_flags[1]) begin
            if (n_inv > SMAX34) begin
                n_n2     = 32'sh7FFF_FFFF;
                n_n2_sat = 1'b1;
            end else if (n_inv < SMIN34) begin
                n_n2     = 32'sh8000_0000;
                n_n2_sat = 1'b1;
            end else begin
                n_n2 = n_inv[31:0];
            end
        end
        n_n2_side     = r_n1_side;
        n_n2_side.sat = r_n1_side.sat | n_n2_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n2_valid <= 1'b0;
        end else if (en) begin
            r_n2_valid <= r_n1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n2      <= n_n2;
            r_n2_side <= n_n2_side;
        end
    end

    // ------------------------------------------------------------------
    // Clamp or split into sign and magnitude for the power.
    // ------------------------------------------------------------------
    logic [31:0] n_x;
    logic        n_xneg;
    t_side       n_n3_side;
    logic        r_n3_valid;
    logic [31:0] r_n3_x;
    t_side       r_n3_side;

    always_comb begin
        n_xneg = 1'b0;
        if (r_map_flags[0]) begin
            if (r_n2 < 32'sd0) begin
                n_x = 32'd0;
            end else if ($signed({2'b00, r_n2}) > ONE34) begin
                n_x = ONE34[31:0];
            end else begin
                n_x = r_n2;
            end
        end else if (r_n2 < 32'sd0) begin
            n_x    = 32'(-$signed({r_n2[31], r_n2}));
            n_xneg = 1'b1;
        end else begin
            n_x = r_n2;
        end
        n_n3_side      = r_n2_side;
        n_n3_side.neg  = n_xneg;
        n_n3_side.zero = (n_x == 32'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n3_valid <= 1'b0;
        end else if (en) begin
            r_n3_valid <= r_n2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n3_x    <= n_x;
            r_n3_side <= n_n3_side;
        end
    end

    // ------------------------------------------------------------------
    // Leading-one position of the power base.
    // ------------------------------------------------------------------
    logic [4:0]  n_lead;
    t_side       n_lz_side;
    logic        r_lz_valid;
    logic [31:0] r_lz_x;
    t_side       r_lz_side;

    always_comb begin
        n_lead = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (r_n3_x[i]) begin
                n_lead = 5'(i);
            end
        end
        n_lz_side      = r_n3_side;
        n_lz_side.expo = {1'b0, n_lead};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lz_valid <= 1'b0;
        end else if (en) begin
            r_lz_valid <= r_n3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lz_x    <= r_n3_x;
            r_lz_side <= n_lz_side;
        end
    end

    // ------------------------------------------------------------------
    // Normalize the base to a Q1.30 mantissa.
    // ------------------------------------------------------------------
    logic [31:0] n_shl;
    logic [30:0] n_mant;
    logic        r_nm_valid;
    logic [30:0] r_nm_m;
    t_side       r_nm_side;

    always_comb begin
        n_shl = r_lz_x << (5'd30 - r_lz_side.expo[4:0]);
        if (r_lz_side.expo[4:0] == 5'd31) begin
            n_mant = r_lz_x[31:1];
        end else begin
            n_mant = n_shl[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nm_valid <= 1'b0;
        end else if (en) begin
            r_nm_valid <= r_lz_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nm_m    <= n_mant;
            r_nm_side <= r_lz_side;
        end
    end

    // ------------------------------------------------------------------
    // Log2 row: one fraction bit per cell, most significant first.
    // ------------------------------------------------------------------
    logic        w_lval  [0:LOGF];
    logic [30:0] w_lm    [0:LOGF];
    logic [29:0] w_lf    [0:LOGF];
    t_side       w_lside [0:LOGF];

    assign w_lval[0]  = r_nm_valid;
    assign w_lm[0]    = r_nm_m;
    assign w_lf[0]    = 30'd0;
    assign w_lside[0] = r_nm_side;

    for (genvar gl = 0; gl < LOGF; gl++) begin : g_log
        rgr_log_cell #(.BIT(LOGF - 1 - gl)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_lval[gl]),
            .i_m     (w_lm[gl]),
            .i_f     (w_lf[gl]),
            .i_side  (w_lside[gl]),
            .o_valid (w_lval[gl+1]),
            .o_m     (w_lm[gl+1]),
            .o_f     (w_lf[gl+1]),
            .o_side  (w_lside[gl+1])
        );
    end

    // ------------------------------------------------------------------
    // Scale the logarithm by gamma.
    // ------------------------------------------------------------------
    logic signed [6:0]  n_eint;
    logic signed [36:0] n_log;
    logic               r_p_valid;
    logic signed [61:0] r_p_prod;
    t_side              r_p_side;

    always_comb begin
        n_eint = $signed({1'b0, w_lside[LOGF].expo}) - 7'(FRAC_BITS);
        n_log  = $signed({n_eint, w_lf[LOGF]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (en) begin
            r_p_valid <= w_lval[LOGF];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_prod <= n_log * $signed({1'b0, n_gamma});
            r_p_side <= w_lside[LOGF];
        end
    end

    // ------------------------------------------------------------------
    // Split the power exponent into integer and fraction parts.
    // ------------------------------------------------------------------
    logic signed [62:0] n_t;
    t_side              n_t_side;
    logic               r_t_valid;
    logic [29:0]        r_t_fp;
    t_side              r_t_side;

    always_comb begin
        n_t         = ($signed({r_p_prod[61], r_p_prod}) >>> GAMMA_FRAC) + FOFS;
        n_t_side    = r_p_side;
        n_t_side.ip = n_t[LOGF+IPW-1:LOGF];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
        end else if (en) begin
            r_t_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t_fp   <= n_t[29:0];
            r_t_side <= n_t_side;
        end
    end

    // ------------------------------------------------------------------
    // Exp2 row: one root constant per cell.
    // ------------------------------------------------------------------
    logic        w_eval  [0:LOGF];
    logic [31:0] w_em    [0:LOGF];
    logic [29:0] w_efp   [0:LOGF];
    t_side       w_eside [0:LOGF];

    assign w_eval[0]  = r_t_valid;
    assign w_em[0]    = 32'd1 << LOGF;
    assign w_efp[0]   = r_t_fp;
    assign w_eside[0] = r_t_side;

    for (genvar ge = 0; ge < LOGF; ge++) begin : g_exp
        rgr_exp_cell #(.K(ge + 1)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_eval[ge]),
            .i_m     (w_em[ge]),
            .i_fp    (w_efp[ge]),
            .i_side  (w_eside[ge]),
            .o_valid (w_eval[ge+1]),
            .o_m     (w_em[ge+1]),
            .o_fp    (w_efp[ge+1]),
            .o_side  (w_eside[ge+1])
        );
    end

    // ------------------------------------------------------------------
    // Shift the mantissa to the value format and restore the sign.
    // ------------------------------------------------------------------
    t_side              n_fs;
    logic [31:0]        n_fm;
    logic signed [IPW:0] n_sh;
    logic [41:0]        n_rnd;
    logic [30:0]        n_pow;
    logic               n_pow_sat;
    logic               r_f1_valid;
    logic signed [31:0] r_f1_n;
    logic               r_f1_sat;

    always_comb begin
        n_fs      = w_eside[LOGF];
        n_fm      = w_em[LOGF];
        n_sh      = (IPW+1)'(LOGF) - $signed({n_fs.ip[IPW-1], n_fs.ip});
        n_rnd     = ({10'd0, n_fm} + (42'd1 << (n_sh[5:0] - 6'd1))) >> n_sh[5:0];
        n_pow_sat = 1'b0;
        if (n_fs.zero) begin
            n_pow = 31'd0;
        end else if (n_fs.ip >= IPW'(31)) begin
            n_pow     = 31'h7FFF_FFFF;
            n_pow_sat = 1'b1;
        end else if (n_fs.ip == IPW'(LOGF)) begin
            if (n_fm[31]) begin
                n_pow     = 31'h7FFF_FFFF;
                n_pow_sat = 1'b1;
            end else begin
                n_pow = n_fm[30:0];
            end
        end else if (n_sh > (IPW+1)'(40)) begin
            n_pow = 31'd0;
        end else begin
            n_pow = n_rnd[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else if (en) begin
            r_f1_valid <= w_eval[LOGF];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_n   <= n_fs.neg ? -$signed({1'b0, n_pow}) : $signed({1'b0, n_pow});
            r_f1_sat <= n_fs.sat | n_pow_sat;
        end
    end

    // ------------------------------------------------------------------
    // Output span product, rounded half up.
    // ------------------------------------------------------------------
    logic signed [64:0] r_m_prod;
    logic               r_m_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= r_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_prod <= n_span * r_f1_n + RND65;
            r_m_sat  <= r_f1_sat;
        end
    end

    // ------------------------------------------------------------------
    // Offset, final saturation and output register.
    // ------------------------------------------------------------------
    logic signed [65:0] n_res;
    logic [31:0]        n_out;
    logic               n_out_sat;
    logic [31:0]        r_out_data;
    logic               r_out_sat;

    always_comb begin
        n_res     = ($signed({r_m_prod[64], r_m_prod}) >>> FRAC_BITS)
                  + $signed({{34{r_output_min[31]}}, r_output_min});
        n_out_sat = r_m_sat;
        if (r_const_mode) begin
            n_out     = r_const_value;
            n_out_sat = 1'b0;
        end else if (n_res > SMAX66) begin
            n_out     = 32'h7FFF_FFFF;
            n_out_sat = 1'b1;
        end else if (n_res < SMIN66) begin
            n_out     = 32'h8000_0000;
            n_out_sat = 1'b1;
        end else begin
            n_out = n_res[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_out_load) begin
            r_out_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_out_load) begin
            r_out_data <= n_out;
            r_out_sat  <= n_out_sat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_sat;

endmodule

[rtl/core/rgr_checker.sv]
// ----------------------------------------------------------------------------
// Range gamma remap port checker
// Watches the ports of the core for flow-control and reset behavior.
// ----------------------------------------------------------------------------
module rgr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        psel,
    input logic        pready
);

    // Reset leaves no result beat pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat valid right after reset");

    // With the output register empty nothing can hold back the input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output register is empty");

    // The register port never inserts wait states.
    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel |-> pready)
        else $error("pready low during an access");

    // A blocked result beat holds its value and flag.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("blocked output beat changed");

endmodule

bind range_gamma_remap_core rgr_checker u_rgr_checker (.*);
